/* sv/itrd_pkg.sv */
// Shared types, constants and a function for the integer to radix digits block.
package itrd_pkg;

  localparam int VALUE_W            = 64;
  localparam int RADIX_W            = 6;
  localparam int MIN_W              = 7;
  localparam int CHAR_W             = 7;
  localparam int DIGIT_W            = 6;
  localparam int OUT_TDATA_W        = 8;
  localparam int CFG_ADDR_W         = 1;
  localparam int CFG_DATA_W         = 7;
  localparam int MAX_DIGITS_DEFAULT = 64;
  localparam int DIV_BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES         = VALUE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LETTER = CHAR_W'(65);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIX      = 1'b0,
    REG_MIN_DIGITS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic div;
    logic store;
    logic emit_start;
    logic rd;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_digit;
    logic emit_last;
  } dp_status_t;

  // Maps a digit value to its character; values past 35 wrap around by 36.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] m;
    m = (d >= DIGIT_W'(36)) ? d - DIGIT_W'(36) : d;
    if (m < DIGIT_W'(10)) begin
      digit_char = CHAR_ZERO + CHAR_W'(m);
    end else begin
      digit_char = CHAR_LETTER + CHAR_W'(m - DIGIT_W'(10));
    end
  endfunction

endpackage

/* sv/itrd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/itrd_datapath.sv */
// Datapath: configuration registers, digit division unit, digit store and character output.
module itrd_datapath #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  itrd_pkg::ctrl_cmd_t                 cmd,
  output itrd_pkg::dp_status_t                status,
  input  logic [itrd_pkg::VALUE_W-1:0]        value,
  input  logic                                cfg_we,
  input  logic [itrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [itrd_pkg::CHAR_W-1:0]         char_code,
  output logic                                last_char
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam logic [itrd_pkg::MIN_W-1:0] MIN_LIMIT = itrd_pkg::MIN_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

  logic [itrd_pkg::RADIX_W-1:0] radix;
  logic [itrd_pkg::MIN_W-1:0]   min_digits;
  logic [itrd_pkg::RADIX_W-1:0] radix_eff;
  logic [CNT_W-1:0]             width_eff;
  logic [itrd_pkg::VALUE_W-1:0] num;
  logic [itrd_pkg::VALUE_W-1:0] num_next;
  logic [itrd_pkg::DIGIT_W-1:0] rem;
  logic [itrd_pkg::DIGIT_W-1:0] rem_next;
  logic [CNT_W-1:0]             digit_count;
  logic [CNT_W-1:0]             emit_idx;
  logic [CNT_W-1:0]             total;
  logic [itrd_pkg::DIGIT_W-1:0] rd_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= itrd_pkg::RADIX_RESET;
      min_digits <= '0;
    end else if (cfg_we) begin
      case (itrd_pkg::cfg_reg_t'(cfg_addr))
        itrd_pkg::REG_RADIX:      radix      <= cfg_wdata[itrd_pkg::RADIX_W-1:0];
        itrd_pkg::REG_MIN_DIGITS: min_digits <= cfg_wdata[itrd_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix < itrd_pkg::RADIX_MIN) begin
      radix_eff = itrd_pkg::RADIX_MIN;
    end else if (radix > itrd_pkg::RADIX_MAX) begin
      radix_eff = itrd_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
    if (min_digits > MIN_LIMIT) begin
      width_eff = CNT_MAX;
    end else begin
      width_eff = CNT_W'(min_digits);
    end
    total = (digit_count > width_eff) ? digit_count : width_eff;
  end

  // Restoring division, several quotient bits per cycle; the quotient shifts into num.
  always_comb begin
    logic [itrd_pkg::DIGIT_W:0] trial;
    num_next = num;
    rem_next = rem;
    for (int i = 0; i < itrd_pkg::DIV_BITS_PER_CYCLE; i++) begin
      trial    = {rem_next, num_next[itrd_pkg::VALUE_W-1]};
      num_next = {num_next[itrd_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_eff}) begin
        rem_next    = itrd_pkg::DIGIT_W'(trial - {1'b0, radix_eff});
        num_next[0] = 1'b1;
      end else begin
        rem_next = trial[itrd_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= value;
      rem <= '0;
    end else if (cmd.div) begin
      num <= num_next;
      rem <= rem_next;
    end else if (cmd.store) begin
      rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (cmd.load) begin
      digit_count <= '0;
    end else if (cmd.store) begin
      digit_count <= digit_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_idx <= total - CNT_W'(1);
    end else if (cmd.emit_next) begin
      emit_idx <= emit_idx - CNT_W'(1);
    end
  end

  itrd_ram #(
    .WIDTH(itrd_pkg::DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digit_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(digit_count[IDX_W-1:0]),
    .wdata(rem),
    .re   (cmd.rd),
    .raddr(emit_idx[IDX_W-1:0]),
    .rdata(rd_digit)
  );

  assign status.last_digit = (num == '0) || (digit_count == CNT_LAST);
  assign status.emit_last  = (emit_idx == '0);

  assign char_code = (emit_idx < digit_count) ? itrd_pkg::digit_char(rd_digit)
                                              : itrd_pkg::CHAR_ZERO;
  assign last_char = (emit_idx == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_MAX)
    else $error("digit count exceeds store depth");

  a_rem_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> rem == '0)
    else $error("remainder not cleared after digit store");

  a_emit_covers: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |=> (emit_idx + CNT_W'(1)) >= digit_count)
    else $error("emit length shorter than digit count");

endmodule

/* sv/itrd_ctrl.sv */
// Controller: sequences loading, division steps, digit stores and character output.
module itrd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output itrd_pkg::ctrl_cmd_t  cmd,
  input  itrd_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    STORE,
    EMIT_START,
    EMIT_RD,
    EMIT_SHOW
  } state_t;

  localparam logic [itrd_pkg::DIV_CNT_W-1:0] STEP_LAST =
    itrd_pkg::DIV_CNT_W'(itrd_pkg::DIV_CYCLES - 1);

  state_t                           state;
  logic [itrd_pkg::DIV_CNT_W-1:0]   step_cnt;

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == EMIT_SHOW);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == IDLE) && s_tvalid;
    cmd.div        = (state == DIV);
    cmd.store      = (state == STORE);
    cmd.emit_start = (state == EMIT_START);
    cmd.rd         = (state == EMIT_RD);
    cmd.emit_next  = (state == EMIT_SHOW) && m_tready && !status.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        IDLE: begin
          step_cnt <= '0;
          if (s_tvalid) begin
            state <= DIV;
          end
        end
        DIV: begin
          step_cnt <= step_cnt + itrd_pkg::DIV_CNT_W'(1);
          if (step_cnt == STEP_LAST) begin
            state <= STORE;
          end
        end
        STORE: begin
          step_cnt <= '0;
          state    <= status.last_digit ? EMIT_START : DIV;
        end
        EMIT_START: state <= EMIT_RD;
        EMIT_RD:    state <= EMIT_SHOW;
        EMIT_SHOW: begin
          if (m_tready) begin
            state <= status.emit_last ? IDLE : EMIT_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_store_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == STORE) |-> $past(state == DIV))
    else $error("digit stored without a full division");

  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while characters are pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_SHOW) && m_tready && status.emit_last |=> state == IDLE)
    else $error("run did not end after its last character");

endmodule

/* sv/integer_to_radix_digits_core.sv */
// Top level of the integer to radix digits converter.
//
//   Channel  Direction  Signals                      Content
//   s_*      in         s_tvalid s_tready s_tdata    value to convert
//   m_*      out        m_tvalid m_tready m_tdata    one character, tlast on the final one
//   cfg_*    in         cfg_we cfg_addr cfg_wdata    radix (0), min_digits (1)
//
// Each digit takes a full division in the division unit, which retires 8 quotient
// bits a cycle, and then a store state; each output character passes through the
// EMIT_RD and EMIT_SHOW states for the registered digit store read. One item is
// handled at a time and a stalled output holds the block. Reset is synchronous;
// the digit store needs none.
module integer_to_radix_digits_core #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [itrd_pkg::VALUE_W-1:0]        s_tdata,   // [63:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [itrd_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [6:0] char_code, [7] zero
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [itrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  itrd_pkg::ctrl_cmd_t        cmd;
  itrd_pkg::dp_status_t       status;
  logic [itrd_pkg::CHAR_W-1:0] char_code;

  itrd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .status  (status)
  );

  itrd_datapath #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .value    (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .char_code(char_code),
    .last_char(m_tlast)
  );

  assign m_tdata = {1'b0, char_code};

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the integer to radix digits converter.
module tb_top;

  localparam int          DIGITS_MAX = 64;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [6:0]  CHAR_0 = 7'h30;
  localparam logic [6:0]  CHAR_A = 7'h41;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_exp_t;

  typedef struct {
    logic [5:0]  radix;
    logic [6:0]  min_d;
    logic [63:0] value;
    string       want;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [itrd_pkg::VALUE_W-1:0]     s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [itrd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;
  logic                             cfg_we = 1'b0;
  logic [itrd_pkg::CFG_ADDR_W-1:0]  cfg_addr = itrd_pkg::REG_RADIX;
  logic [itrd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  char_exp_t   pending_chars[$];
  logic [5:0]  cur_radix = 6'd2;
  logic [6:0]  cur_min = 7'd0;
  logic [5:0]  digit_mem [DIGITS_MAX];
  int          digit_cnt;
  int          bad_chars = 0;
  int          cycles = 0;
  int          tx_gap_pct = 7;
  int          rx_stall_pct = 46;
  dir_row_t    dir_tab [25];

  integer_to_radix_digits_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic void note_mismatch(input string what, input char_exp_t exp_c,
                                        input logic [7:0] got_data, input logic got_last);
    bad_chars++;
    if (bad_chars <= 10) begin
      $display("mismatch (%s): expected char %h last %b, got tdata %h tlast %b",
               what, exp_c.code, exp_c.last, got_data, got_last);
    end
  endfunction

  function automatic void expect_char(input char_exp_t c);
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  always @(posedge clk) begin
    char_exp_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch("unexpected item", '0, m_tdata, m_tlast);
      end else begin
        e = pending_chars.pop_front();
        if (m_tdata !== {1'b0, e.code} || m_tlast !== e.last) begin
          note_mismatch("wrong field", e, m_tdata, m_tlast);
        end
      end
    end
  end

  function automatic void predict_digits(input logic [63:0] v);
    logic [63:0] base;
    logic [63:0] rest;
    logic [5:0]  d;
    int          width;
    int          total;
    char_exp_t   c;
    base = 64'(cur_radix);
    if (base < 2) base = 2;
    if (base > 36) base = 36;
    width = (cur_min > DIGITS_MAX) ? DIGITS_MAX : int'(cur_min);
    rest = v;
    digit_cnt = 0;
    do begin
      digit_mem[digit_cnt] = 6'(rest % base);
      rest = rest / base;
      digit_cnt++;
    end while (rest != 0 && digit_cnt < DIGITS_MAX);
    total = (digit_cnt > width) ? digit_cnt : width;
    for (int k = 0; k < total; k++) begin
      if (k < total - digit_cnt) begin
        c.code = CHAR_0;
      end else begin
        d = digit_mem[total - 1 - k];
        c.code = (d < 10) ? CHAR_0 + 7'(d) : CHAR_A + 7'(d - 10);
      end
      c.last = (k == total - 1);
      expect_char(c);
    end
  endfunction

  task automatic send_value(input logic [63:0] v, input string want);
    char_exp_t c;
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    if (want.len() == 0) begin
      predict_digits(v);
    end else begin
      for (int k = 0; k < want.len(); k++) begin
        c.code = 7'(want[k]);
        c.last = (k == want.len() - 1);
        expect_char(c);
      end
    end
  endtask

  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] radix, input logic [6:0] min_d);
    cfg_we <= 1'b1;
    cfg_addr <= itrd_pkg::REG_RADIX;
    cfg_wdata <= {1'($urandom_range(1)), radix};
    @(posedge clk);
    cfg_addr <= itrd_pkg::REG_MIN_DIGITS;
    cfg_wdata <= min_d;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_radix = radix;
    cur_min = min_d;
  endtask

  initial begin
    logic [5:0]  r;
    logic [6:0]  m;
    logic [63:0] v;
    dir_tab = '{
      '{6'd2,  7'd0,   64'd0,     "0"},
      '{6'd2,  7'd0,   64'd1,     "1"},
      '{6'd2,  7'd0,   64'd5,     "101"},
      '{6'd2,  7'd0,   ALL_ONES,  ""},
      '{6'd10, 7'd0,   64'd0,     "0"},
      '{6'd10, 7'd0,   ALL_ONES,  "18446744073709551615"},
      '{6'd16, 7'd0,   ALL_ONES,  "FFFFFFFFFFFFFFFF"},
      '{6'd16, 7'd0,   64'h8000_0000_0000_0000, "8000000000000000"},
      '{6'd36, 7'd0,   ALL_ONES,  ""},
      '{6'd36, 7'd0,   64'd35,    "Z"},
      '{6'd36, 7'd0,   64'd36,    "10"},
      '{6'd0,  7'd0,   64'd6,     "110"},
      '{6'd1,  7'd0,   64'd6,     "110"},
      '{6'd37, 7'd0,   64'd35,    "Z"},
      '{6'd63, 7'd0,   64'd36,    "10"},
      '{6'd10, 7'd5,   64'd42,    "00042"},
      '{6'd10, 7'd5,   64'd0,     "00000"},
      '{6'd10, 7'd3,   64'd12345, "12345"},
      '{6'd10, 7'd1,   64'd9,     "9"},
      '{6'd2,  7'd64,  64'd0,     ""},
      '{6'd2,  7'd64,  ALL_ONES,  ""},
      '{6'd2,  7'd127, 64'd1,     ""},
      '{6'd16, 7'd65,  64'hABC,   ""},
      '{6'd3,  7'd0,   ALL_ONES,  ""},
      '{6'd11, 7'd0,   64'd10,    "A"}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].radix != cur_radix || dir_tab[i].min_d != cur_min) begin
        drain(4);
        set_config(dir_tab[i].radix, dir_tab[i].min_d);
      end
      send_value(dir_tab[i].value, dir_tab[i].want);
    end

    for (int chunk = 0; chunk < 11; chunk++) begin
      if (chunk == 0) begin
        r = 6'd2;
        m = 7'd0;
      end else if (chunk == 1) begin
        r = 6'd36;
        m = 7'd64;
      end else if (chunk == 2) begin
        r = 6'd63;
        m = 7'd127;
      end else begin
        case ($urandom_range(9))
          0: r = 6'($urandom_range(1));
          1: r = 6'($urandom_range(63, 37));
          2: r = 6'd2;
          3: r = 6'd36;
          default: r = 6'($urandom_range(36, 2));
        endcase
        case ($urandom_range(9))
          0: m = 7'd64;
          1: m = 7'($urandom_range(127, 65));
          2, 3: m = 7'($urandom_range(40, 9));
          default: m = 7'($urandom_range(8));
        endcase
      end
      if (chunk == 4) begin
        tx_gap_pct = 46;
        rx_stall_pct = 7;
      end else if (chunk == 8) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      drain(4);
      set_config(r, m);
      for (int i = 0; i < 30; i++) begin
        case ($urandom_range(9))
          0: v = 64'd0;
          1: v = ALL_ONES;
          2: v = 64'($urandom_range(1000));
          3: v = {$urandom, $urandom};
          default: v = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        send_value(v, "");
      end
    end

    drain(20);
    if (bad_chars == 0 && pending_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
